// ===== sv/wgm_pkg.sv =====
`timescale 1ns / 1ps

package wgm_pkg;

    localparam int MAX_PATTERN_DEF = 32;

    localparam logic [7:0] ANY_ONE = 8'h3F;
    localparam logic [7:0] ANY_RUN = 8'h2A;

    typedef enum logic [1:0] {
        REQ_CLEAR  = 2'd0,
        REQ_APPEND = 2'd1,
        REQ_TEXT   = 2'd2,
        REQ_END    = 2'd3
    } req_t;

    // shared controls broadcast along the row of cells
    typedef struct packed {
        logic       step;
        logic       rearm;
        logic [7:0] text_byte;
    } gm_ctrl_t;

    function automatic logic [7:0] fold_case(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= 8'h41 && c <= 8'h5A)
        begin
            r = c + 8'h20;
        end
        return r;
    endfunction

endpackage

// ===== sv/wildcard_glob_matcher.sv =====
`timescale 1ns / 1ps

// Case-insensitive glob matcher ('?' one byte, '*' any run, A-Z folded).
// Input channel s_axis: tuser carries the request kind (clear pattern,
// append pattern byte, text byte, end of text), tdata the byte.
// Output channel m_axis: one result per end-of-text request, tdata bit 0
// matched, bit 1 pattern overflow (bytes dropped since the last clear).
// The row of cells updates all pattern positions in parallel, so one
// request per clock is sustained for any text length while s_axis_tready
// is high. Each result sits in a two-entry output register; s_axis_tready
// drops only while both entries are full, so the input side keeps going
// while a result waits. When m_axis_tready is held low, requests still
// flow until a second result is stored.
// After reset the pattern is empty, the overflow flag is clear and the
// matcher is armed for a new text; the block takes requests at once.
// Appending a byte abandons any text in progress.

module wildcard_glob_matcher #(
    parameter int MAX_PATTERN = wgm_pkg::MAX_PATTERN_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] char_value
    input  logic [1:0] s_axis_tuser,   // [1:0] req_type
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata    // [0] matched, [1] pattern_overflow, [7:2] zero
);
    import wgm_pkg::*;

    localparam int LW = $clog2(MAX_PATTERN + 1);
    localparam int NP = MAX_PATTERN + 1;

    req_t       req;
    logic       accept;
    logic [7:0] folded;
    gm_ctrl_t   ctrl;

    logic [LW-1:0] len_reg;
    logic [LW-1:0] len_next;
    logic          ovf_reg;
    logic          ovf_next;
    logic          act_last_reg;
    logic          act_last_next;

    logic [NP-1:0] act_vec;
    logic [NP-1:0] star_vec;
    logic [NP-1:0] closed_vec;
    logic [NP-1:0] adv_vec;

    logic       push;
    logic       pop;
    logic [1:0] res;
    logic       head_valid_reg;
    logic       head_valid_next;
    logic [1:0] head_data_reg;
    logic [1:0] head_data_next;
    logic       skid_valid_reg;
    logic       skid_valid_next;
    logic [1:0] skid_data_reg;
    logic [1:0] skid_data_next;

    assign req    = req_t'(s_axis_tuser);
    assign accept = s_axis_tvalid && s_axis_tready;
    assign folded = fold_case(s_axis_tdata);

    assign ctrl.step      = accept && (req == REQ_TEXT);
    assign ctrl.rearm     = accept && (req != REQ_TEXT);
    assign ctrl.text_byte = folded;

    assign adv_vec[0] = 1'b0;

    genvar i;
    generate
        for (i = 0; i < MAX_PATTERN; i++)
        begin : g_cell
            wgm_cell #(
                .START_BIT (i == 0)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctrl      (ctrl),
                .wr_en     (accept && (req == REQ_APPEND) && (len_reg == LW'(i))),
                .wr_byte   (folded),
                .in_use    (len_reg > LW'(i)),
                .closed_in (closed_vec[i]),
                .adv_in    (adv_vec[i]),
                .act       (act_vec[i]),
                .star      (star_vec[i]),
                .adv_out   (adv_vec[i+1])
            );
        end
    endgenerate

    // position past the last pattern byte has no byte of its own
    assign act_vec[MAX_PATTERN]  = act_last_reg;
    assign star_vec[MAX_PATTERN] = 1'b0;

    wgm_closure #(
        .N (NP)
    ) u_closure (
        .act    (act_vec),
        .star   (star_vec),
        .closed (closed_vec)
    );

    always_comb
    begin
        len_next      = len_reg;
        ovf_next      = ovf_reg;
        act_last_next = act_last_reg;
        if (ctrl.rearm)
        begin
            act_last_next = 1'b0;
        end
        else if (ctrl.step)
        begin
            act_last_next = adv_vec[MAX_PATTERN];
        end
        if (accept)
        begin
            case (req)
                REQ_CLEAR:
                begin
                    len_next = '0;
                    ovf_next = 1'b0;
                end
                REQ_APPEND:
                begin
                    if (len_reg < LW'(MAX_PATTERN))
                    begin
                        len_next = len_reg + 1'b1;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                end
                default:
                begin
                    len_next = len_reg;
                end
            endcase
        end
    end

    // two-entry output register
    assign push = accept && (req == REQ_END);
    assign pop  = head_valid_reg && m_axis_tready;
    assign res  = {ovf_reg, closed_vec[len_reg]};

    always_comb
    begin
        head_valid_next = head_valid_reg;
        head_data_next  = head_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (pop)
        begin
            head_valid_next = skid_valid_reg;
            head_data_next  = skid_data_reg;
            skid_valid_next = 1'b0;
            if (push)
            begin
                if (skid_valid_reg)
                begin
                    skid_valid_next = 1'b1;
                    skid_data_next  = res;
                end
                else
                begin
                    head_valid_next = 1'b1;
                    head_data_next  = res;
                end
            end
        end
        else if (push)
        begin
            if (!head_valid_reg)
            begin
                head_valid_next = 1'b1;
                head_data_next  = res;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_data_next  = res;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg        <= '0;
            ovf_reg        <= 1'b0;
            act_last_reg   <= 1'b0;
            head_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            len_reg        <= len_next;
            ovf_reg        <= ovf_next;
            act_last_reg   <= act_last_next;
            head_valid_reg <= head_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_data_reg <= head_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign s_axis_tready = !skid_valid_reg;
    assign m_axis_tvalid = head_valid_reg;
    assign m_axis_tdata  = {6'b0, head_data_reg};

    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= LW'(MAX_PATTERN))
        else $error("pattern length beyond capacity");

    a_skid_needs_head: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> head_valid_reg)
        else $error("skid entry held with empty head");

    a_clear_resets: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (req == REQ_CLEAR)) |=> (len_reg == '0) && !ovf_reg)
        else $error("clear request left pattern state");

    a_rearm_start: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.rearm |=> (act_vec == NP'(1)))
        else $error("matcher not back at start position");

    a_end_result: assert property (@(posedge clk) disable iff (!rst_n)
        push |=> m_axis_tvalid)
        else $error("end of text produced no result");

endmodule

// ===== sv/wgm_cell.sv =====
`timescale 1ns / 1ps

module wgm_cell #(
    parameter bit START_BIT = 1'b0
) (
    input  logic              clk,
    input  logic              rst_n,
    input  wgm_pkg::gm_ctrl_t ctrl,
    input  logic              wr_en,
    input  logic [7:0]        wr_byte,
    input  logic              in_use,
    input  logic              closed_in,
    input  logic              adv_in,
    output logic              act,
    output logic              star,
    output logic              adv_out
);
    import wgm_pkg::*;

    logic [7:0] byte_reg;
    logic       act_reg;
    logic       act_next;
    logic       match;
    logic       stay;

    // pattern byte is kept already folded to lower case
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            byte_reg <= wr_byte;
        end
    end

    assign star  = in_use && (byte_reg == ANY_RUN);
    assign match = in_use && !star &&
                   ((byte_reg == ANY_ONE) || (byte_reg == ctrl.text_byte));

    assign stay    = closed_in && star;
    assign adv_out = closed_in && match;

    always_comb
    begin
        act_next = act_reg;
        if (ctrl.rearm)
        begin
            act_next = START_BIT;
        end
        else if (ctrl.step)
        begin
            act_next = stay || adv_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg <= START_BIT;
        end
        else
        begin
            act_reg <= act_next;
        end
    end

    assign act = act_reg;

endmodule

// ===== sv/wgm_closure.sv =====
`timescale 1ns / 1ps

module wgm_closure #(
    parameter int N = 33
) (
    input  logic [N-1:0] act,
    input  logic [N-1:0] star,
    output logic [N-1:0] closed
);
    logic [N-1:0] seed;
    logic [N-1:0] sum;

    // carries of star + (act & star) fill each run of stars from its lowest
    // active position up to one past the run
    assign seed   = act & star;
    assign sum    = star + seed;
    assign closed = act | (sum ^ star ^ seed);

endmodule
